// ===== rtl/core/etsplit_pkg.sv =====
// etsplit_pkg: shared types, field widths and calendar constants for elapsed_time_split
// no dependencies; imported by every module in rtl/core

package etsplit_pkg;

    localparam int IN_W  = 80;
    localparam int OUT_W = 120;

    localparam int YEAR_W = 12;
    localparam int DAY_W  = 9;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    localparam int YMAG_W = 13;
    localparam int THR_W  = 26;
    localparam int TMIN_W = 32;

    localparam int TSEC_OUT_W = 33;
    localparam int TMIN_OUT_W = 27;
    localparam int THR_OUT_W  = 21;
    localparam int PSEC_OUT_W = 7;
    localparam int PMIN_OUT_W = 7;
    localparam int PHR_OUT_W  = 6;
    localparam int PDAY_OUT_W = 10;
    localparam int PYR_OUT_W  = 8;

    localparam logic [9:0] SECS_PER_MIN  = 10'd60;
    localparam logic [9:0] MINS_PER_HOUR = 10'd60;
    localparam logic [9:0] HOURS_PER_DAY = 10'd24;
    localparam logic [9:0] DAYS_PER_YEAR = 10'd365;

    localparam logic [13:0] HOURS_PER_YEAR = 14'd8760;

    typedef struct packed {
        logic [YEAR_W-1:0] yr;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hr;
        logic [MIN_W-1:0]  mn;
        logic [SEC_W-1:0]  sc;
    } stamp_t;

    typedef struct packed {
        logic [YMAG_W-1:0] yr;
        logic [DAY_W-1:0]  day;
        logic [HOUR_W-1:0] hr;
        logic [MIN_W-1:0]  mn;
        logic [SEC_W-1:0]  sc;
        logic              neg;
    } mag_t;

    typedef struct packed {
        logic [TSEC_OUT_W-1:0] t_sec;
        logic [TMIN_OUT_W-1:0] t_min;
        logic [THR_OUT_W-1:0]  t_hr;
        logic [PYR_OUT_W-1:0]  yr;
        logic [DAY_W-1:0]      day;
        logic [HOUR_W-1:0]     hr;
        logic [MIN_W-1:0]      mn;
        logic [SEC_W-1:0]      sc;
        logic                  neg;
    } scaled_t;

    typedef struct packed {
        logic [8:0]        digit;
        logic signed [1:0] carry;
    } norm_t;

    // floor-normalize a signed digit with |v| < 2*radix into digit and carry -2..1
    function automatic norm_t norm_digit(input logic signed [13:0] v,
                                         input logic [9:0] radix);
        logic signed [13:0] r;
        norm_t n;
        r = $signed({4'b0, radix});
        if (v < -r)
        begin
            n.digit = 9'(v + r + r);
            n.carry = 2'b10;
        end
        else if (v < 14'sd0)
        begin
            n.digit = 9'(v + r);
            n.carry = 2'b11;
        end
        else if (v >= r)
        begin
            n.digit = 9'(v - r);
            n.carry = 2'b01;
        end
        else
        begin
            n.digit = 9'(v);
            n.carry = 2'b00;
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/etsplit_norm.sv =====
// etsplit_norm: stages 1-3, field differences, mixed-radix normalization, sign fold
// depends on etsplit_pkg

module etsplit_norm
    import etsplit_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  stamp_t cur,
    input  stamp_t tgt,
    output logic   out_valid,
    output mag_t   mag
);

    // stage 1
    logic               v1_reg;
    logic [SEC_W-1:0]   sc1_reg, sc1_next;
    logic [MIN_W-1:0]   mn1_reg, mn1_next;
    logic signed [1:0]  c1_reg, c1_next;
    logic signed [5:0]  dh1_reg, dh1_next;
    logic signed [9:0]  dd1_reg, dd1_next;
    logic signed [12:0] dy1_reg, dy1_next;

    logic signed [6:0]  ds, dm;
    logic signed [7:0]  mp;
    norm_t              ns, nm;

    always_comb
    begin
        ds = $signed({1'b0, cur.sc}) - $signed({1'b0, tgt.sc});
        dm = $signed({1'b0, cur.mn}) - $signed({1'b0, tgt.mn});
        ns = norm_digit($signed({{7{ds[6]}}, ds}), SECS_PER_MIN);
        mp = $signed({dm[6], dm}) + $signed({{6{ns.carry[1]}}, ns.carry});
        nm = norm_digit($signed({{6{mp[7]}}, mp}), MINS_PER_HOUR);
        sc1_next = ns.digit[SEC_W-1:0];
        mn1_next = nm.digit[MIN_W-1:0];
        c1_next  = nm.carry;
        dh1_next = $signed({1'b0, cur.hr}) - $signed({1'b0, tgt.hr});
        dd1_next = $signed({1'b0, cur.day}) - $signed({1'b0, tgt.day});
        dy1_next = $signed({1'b0, cur.yr}) - $signed({1'b0, tgt.yr});
    end

    // stage 2
    logic               v2_reg;
    logic signed [13:0] yp2_reg, yp2_next;
    logic [DAY_W-1:0]   day2_reg, day2_next;
    logic [HOUR_W-1:0]  hr2_reg, hr2_next;
    logic [MIN_W-1:0]   mn2_reg;
    logic [SEC_W-1:0]   sc2_reg;

    logic signed [13:0] hp, dp;
    norm_t              nh, nd;

    always_comb
    begin
        hp = $signed({{8{dh1_reg[5]}}, dh1_reg}) + $signed({{12{c1_reg[1]}}, c1_reg});
        nh = norm_digit(hp, HOURS_PER_DAY);
        dp = $signed({{4{dd1_reg[9]}}, dd1_reg}) + $signed({{12{nh.carry[1]}}, nh.carry});
        nd = norm_digit(dp, DAYS_PER_YEAR);
        yp2_next  = $signed({dy1_reg[12], dy1_reg}) + $signed({{12{nd.carry[1]}}, nd.carry});
        day2_next = nd.digit;
        hr2_next  = nh.digit[HOUR_W-1:0];
    end

    // stage 3
    logic       v3_reg;
    mag_t       mag3_reg, mag3_next;
    logic       b0, b1, b2, b3;
    logic [6:0] mn_b;
    logic [5:0] hr_b;
    logic [9:0] day_b;
    logic [13:0] yneg;

    always_comb
    begin
        b0    = (sc2_reg != '0);
        mn_b  = {1'b0, mn2_reg} + 7'(b0);
        b1    = (mn_b != '0);
        hr_b  = {1'b0, hr2_reg} + 6'(b1);
        b2    = (hr_b != '0);
        day_b = {1'b0, day2_reg} + 10'(b2);
        b3    = (day_b != '0);
        yneg  = 14'(-yp2_reg) - 14'(b3);
        mag3_next.neg = yp2_reg[13];
        if (yp2_reg[13])
        begin
            mag3_next.sc  = b0 ? 6'(7'(SECS_PER_MIN) - {1'b0, sc2_reg}) : '0;
            mag3_next.mn  = b1 ? 6'(7'(MINS_PER_HOUR) - mn_b) : '0;
            mag3_next.hr  = b2 ? 5'(6'(HOURS_PER_DAY) - hr_b) : '0;
            mag3_next.day = b3 ? 9'(DAYS_PER_YEAR - day_b) : '0;
            mag3_next.yr  = yneg[YMAG_W-1:0];
        end
        else
        begin
            mag3_next.sc  = sc2_reg;
            mag3_next.mn  = mn2_reg;
            mag3_next.hr  = hr2_reg;
            mag3_next.day = day2_reg;
            mag3_next.yr  = yp2_reg[YMAG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc1_reg  <= sc1_next;
            mn1_reg  <= mn1_next;
            c1_reg   <= c1_next;
            dh1_reg  <= dh1_next;
            dd1_reg  <= dd1_next;
            dy1_reg  <= dy1_next;
            yp2_reg  <= yp2_next;
            day2_reg <= day2_next;
            hr2_reg  <= hr2_next;
            mn2_reg  <= mn1_reg;
            sc2_reg  <= sc1_reg;
            mag3_reg <= mag3_next;
        end
    end

    assign out_valid = v3_reg;
    assign mag       = mag3_reg;

endmodule

// ===== rtl/core/etsplit_scale.sv =====
// etsplit_scale: stages 4-6, total hours, minutes and seconds from magnitude digits
// depends on etsplit_pkg

module etsplit_scale
    import etsplit_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    in_valid,
    input  mag_t    mag,
    output logic    out_valid,
    output scaled_t scaled
);

    logic              v4_reg, v5_reg, v6_reg;
    mag_t              mag4_reg, mag5_reg;
    logic [THR_W-1:0]  thr4_reg, thr4_next;
    logic [THR_W-1:0]  thr5_reg;
    logic [TMIN_W-1:0] tmin5_reg, tmin5_next;
    scaled_t           out6_reg, out6_next;

    always_comb
    begin
        thr4_next = 26'({13'b0, mag.yr} * 26'(HOURS_PER_YEAR))
                  + 26'({17'b0, mag.day} * 26'(HOURS_PER_DAY))
                  + 26'(mag.hr);
        tmin5_next = 32'({6'b0, thr4_reg} * 32'(MINS_PER_HOUR)) + 32'(mag4_reg.mn);

        out6_next.t_sec = 33'({1'b0, tmin5_reg} * 33'(SECS_PER_MIN)) + 33'(mag5_reg.sc);
        out6_next.t_min = tmin5_reg[TMIN_OUT_W-1:0];
        out6_next.t_hr  = thr5_reg[THR_OUT_W-1:0];
        out6_next.yr    = mag5_reg.yr[PYR_OUT_W-1:0];
        out6_next.day   = mag5_reg.day;
        out6_next.hr    = mag5_reg.hr;
        out6_next.mn    = mag5_reg.mn;
        out6_next.sc    = mag5_reg.sc;
        out6_next.neg   = mag5_reg.neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag4_reg  <= mag;
            thr4_reg  <= thr4_next;
            mag5_reg  <= mag4_reg;
            thr5_reg  <= thr4_reg;
            tmin5_reg <= tmin5_next;
            out6_reg  <= out6_next;
        end
    end

    assign out_valid = v6_reg;
    assign scaled    = out6_reg;

endmodule

// ===== rtl/core/etsplit_sign.sv =====
// etsplit_sign: stage 7, applies the difference sign and holds the output beat
// depends on etsplit_pkg

module etsplit_sign
    import etsplit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  scaled_t          scaled,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_data
);

    logic             v7_reg;
    logic [OUT_W-1:0] data7_reg, data7_next;

    logic [TSEC_OUT_W-1:0] o_tsec;
    logic [TMIN_OUT_W-1:0] o_tmin;
    logic [THR_OUT_W-1:0]  o_thr;
    logic [PSEC_OUT_W-1:0] o_psec;
    logic [PMIN_OUT_W-1:0] o_pmin;
    logic [PHR_OUT_W-1:0]  o_phr;
    logic [PDAY_OUT_W-1:0] o_pday;
    logic [PYR_OUT_W-1:0]  o_pyr;

    always_comb
    begin
        o_tsec = scaled.neg ? -scaled.t_sec : scaled.t_sec;
        o_tmin = scaled.neg ? -scaled.t_min : scaled.t_min;
        o_thr  = scaled.neg ? -scaled.t_hr  : scaled.t_hr;
        o_psec = scaled.neg ? -PSEC_OUT_W'(scaled.sc)  : PSEC_OUT_W'(scaled.sc);
        o_pmin = scaled.neg ? -PMIN_OUT_W'(scaled.mn)  : PMIN_OUT_W'(scaled.mn);
        o_phr  = scaled.neg ? -PHR_OUT_W'(scaled.hr)   : PHR_OUT_W'(scaled.hr);
        o_pday = scaled.neg ? -PDAY_OUT_W'(scaled.day) : PDAY_OUT_W'(scaled.day);
        o_pyr  = scaled.neg ? -scaled.yr : scaled.yr;
        data7_next = {1'b0, o_pyr, o_pday, o_phr, o_pmin, o_psec, o_thr, o_tmin, o_tsec};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v7_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data7_reg <= data7_next;
        end
    end

    assign out_valid = v7_reg;
    assign out_data  = data7_reg;

endmodule

// ===== rtl/core/elapsed_time_split.sv =====
// elapsed_time_split: top level, signed timestamp difference split into time units
// depends on etsplit_pkg, etsplit_norm, etsplit_scale, etsplit_sign
//
// channel   dir  width  fields (lowest bit first)
// s_axis    in   80     cur_year, cur_day_of_year, cur_hour, cur_minute, cur_second,
//                       tgt_year, tgt_day_of_year, tgt_hour, tgt_minute, tgt_second
// m_axis    out  120    total_seconds, total_minutes, total_hours, part_seconds,
//                       part_minutes, part_hours, part_days, part_years
//
// seven register stages, one beat per cycle while the output is not stalled
// stages: differences, normalize, sign fold, hours, minutes, seconds, sign/output
// the whole pipeline advances when the output register is empty or taken
// reset clears all valid bits; nothing else needs clearing

module elapsed_time_split
    import etsplit_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // cur y,d,h,m,s then tgt y,d,h,m,s
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // tot s,m,h; part s,m,h,d,y
);

    logic    adv;
    stamp_t  cur, tgt;
    logic    norm_valid, scale_valid;
    mag_t    mag;
    scaled_t scaled;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    assign cur.yr  = s_axis_tdata[11:0];
    assign cur.day = s_axis_tdata[20:12];
    assign cur.hr  = s_axis_tdata[25:21];
    assign cur.mn  = s_axis_tdata[31:26];
    assign cur.sc  = s_axis_tdata[37:32];
    assign tgt.yr  = s_axis_tdata[49:38];
    assign tgt.day = s_axis_tdata[58:50];
    assign tgt.hr  = s_axis_tdata[63:59];
    assign tgt.mn  = s_axis_tdata[69:64];
    assign tgt.sc  = s_axis_tdata[75:70];

    etsplit_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .cur       (cur),
        .tgt       (tgt),
        .out_valid (norm_valid),
        .mag       (mag)
    );

    etsplit_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (norm_valid),
        .mag       (mag),
        .out_valid (scale_valid),
        .scaled    (scaled)
    );

    etsplit_sign u_sign
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (scale_valid),
        .scaled    (scaled),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== rtl/core/etsplit_chk.sv =====
// etsplit_chk: port-level checks for elapsed_time_split, bound to the top level
// depends on etsplit_pkg and elapsed_time_split

module etsplit_chk
    import etsplit_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // output beat held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // input side only stalls when the output side does
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // minutes remainder stays within one hour
    a_pmin: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[94:88]) >= -7'sd59)
                       && ($signed(m_axis_tdata[94:88]) <= 7'sd59))
        else $error("minutes remainder out of range");

    // seconds remainder stays within one minute
    a_psec: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[87:81]) >= -7'sd59)
                       && ($signed(m_axis_tdata[87:81]) <= 7'sd59))
        else $error("seconds remainder out of range");

endmodule

bind elapsed_time_split etsplit_chk u_chk (.*);

// ===== verif/testbench.sv =====
// testbench: self-checking bench for elapsed_time_split, timestamp pairs in, split differences out
// depends on etsplit_pkg and the elapsed_time_split rtl; predicts every beat and scoreboards results
// covers directed extremes, random calendar pairs, full-width wraparound and random stalls

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import etsplit_pkg::*;

    localparam longint YEAR_DAYS  = 365;
    localparam longint DAY_HOURS  = 24;
    localparam longint HOUR_MINS  = 60;
    localparam longint MIN_SECS   = 60;
    localparam int     LATENCY    = 7;

    // result field offsets in m_axis_tdata, lowest first
    localparam int TSEC_LO = 0;
    localparam int TMIN_LO = TSEC_LO + TSEC_OUT_W;
    localparam int THR_LO  = TMIN_LO + TMIN_OUT_W;
    localparam int PSEC_LO = THR_LO + THR_OUT_W;
    localparam int PMIN_LO = PSEC_LO + PSEC_OUT_W;
    localparam int PHR_LO  = PMIN_LO + PMIN_OUT_W;
    localparam int PDAY_LO = PHR_LO + PHR_OUT_W;
    localparam int PYR_LO  = PDAY_LO + PDAY_OUT_W;

    typedef struct {
        logic [TSEC_OUT_W-1:0] tot_sec;
        logic [TMIN_OUT_W-1:0] tot_min;
        logic [THR_OUT_W-1:0]  tot_hr;
        logic [PSEC_OUT_W-1:0] sec;
        logic [PMIN_OUT_W-1:0] mins;
        logic [PHR_OUT_W-1:0]  hrs;
        logic [PDAY_OUT_W-1:0] days;
        logic [PYR_OUT_W-1:0]  yrs;
    } elapsed_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_THIRDS, RX_CHOKE} rx_mode_e;

    logic             clk;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;   // cur y,d,h,m,s then tgt y,d,h,m,s
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // tot s,m,h; part s,m,h,d,y

    elapsed_t elapsed_q[$];
    int       pairs_sent    = 0;
    int       results_seen  = 0;
    int       mismatches    = 0;
    int       burst_left    = 0;
    rx_mode_e rx_mode       = RX_OPEN;
    int       rx_left       = 0;
    int       rx_phase      = 0;

    elapsed_time_split i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", elapsed_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic stamp_t mk(input int yr, input int day, input int hr,
                                  input int mn, input int sc);
        stamp_t s;
        s.yr  = YEAR_W'(yr);
        s.day = DAY_W'(day);
        s.hr  = HOUR_W'(hr);
        s.mn  = MIN_W'(mn);
        s.sc  = SEC_W'(sc);
        return s;
    endfunction

    function automatic longint with_sign(input longint mag, input bit neg);
        return neg ? -mag : mag;
    endfunction

    function automatic elapsed_t predict_elapsed(input stamp_t cur, input stamp_t tgt);
        longint   dy, dd, dh, dm, ds, total, mag;
        longint   t_min, p_sec, t_hr, p_min, t_day, p_hr, p_yr, p_day;
        bit       neg;
        elapsed_t r;
        dy = longint'(cur.yr) - longint'(tgt.yr);
        dd = longint'(cur.day) - longint'(tgt.day);
        dh = longint'(cur.hr) - longint'(tgt.hr);
        dm = longint'(cur.mn) - longint'(tgt.mn);
        ds = longint'(cur.sc) - longint'(tgt.sc);
        total = (((dy * YEAR_DAYS + dd) * DAY_HOURS + dh) * HOUR_MINS + dm) * MIN_SECS + ds;
        neg = total < 0;
        mag = neg ? -total : total;
        t_min = mag / MIN_SECS;
        p_sec = mag % MIN_SECS;
        t_hr  = t_min / HOUR_MINS;
        p_min = t_min % HOUR_MINS;
        t_day = t_hr / DAY_HOURS;
        p_hr  = t_hr % DAY_HOURS;
        p_yr  = t_day / YEAR_DAYS;
        p_day = t_day % YEAR_DAYS;
        r.tot_sec = TSEC_OUT_W'(with_sign(mag, neg));
        r.tot_min = TMIN_OUT_W'(with_sign(t_min, neg));
        r.tot_hr  = THR_OUT_W'(with_sign(t_hr, neg));
        r.sec     = PSEC_OUT_W'(with_sign(p_sec, neg));
        r.mins    = PMIN_OUT_W'(with_sign(p_min, neg));
        r.hrs     = PHR_OUT_W'(with_sign(p_hr, neg));
        r.days    = PDAY_OUT_W'(with_sign(p_day, neg));
        r.yrs     = PYR_OUT_W'(with_sign(p_yr, neg));
        return r;
    endfunction

    function automatic stamp_t rand_calendar_stamp();
        return mk($urandom_range(2000, 2099), $urandom_range(0, 365), $urandom_range(0, 23),
                  $urandom_range(0, 59), $urandom_range(0, 59));
    endfunction

    function automatic stamp_t rand_raw_stamp();
        stamp_t s;
        s.yr  = YEAR_W'($urandom);
        s.day = DAY_W'($urandom);
        s.hr  = HOUR_W'($urandom);
        s.mn  = MIN_W'($urandom);
        s.sc  = SEC_W'($urandom);
        return s;
    endfunction

    // called in the time step of a rising edge; returns in such a step
    task automatic send_pair(input stamp_t cur, input stamp_t tgt);
        int gap;
        elapsed_q.push_back(predict_elapsed(cur, tgt));
        s_axis_tdata  <= {4'b0, tgt.sc, tgt.mn, tgt.hr, tgt.day, tgt.yr,
                          cur.sc, cur.mn, cur.hr, cur.day, cur.yr};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        pairs_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (elapsed_q.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic test_directed();
        // zero difference
        send_pair(mk(2023, 100, 12, 30, 30), mk(2023, 100, 12, 30, 30));
        send_pair(mk(0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0));
        send_pair(mk(4095, 511, 31, 63, 63), mk(4095, 511, 31, 63, 63));
        // calendar extremes both ways
        send_pair(mk(2099, 365, 23, 59, 59), mk(2000, 0, 0, 0, 0));
        send_pair(mk(2000, 0, 0, 0, 0), mk(2099, 365, 23, 59, 59));
        send_pair(mk(2099, 364, 23, 59, 59), mk(2000, 0, 0, 0, 0));
        // single units and borrow chains
        send_pair(mk(2050, 10, 5, 0, 1), mk(2050, 10, 5, 0, 0));
        send_pair(mk(2050, 10, 5, 0, 0), mk(2050, 10, 5, 0, 1));
        send_pair(mk(2050, 10, 0, 0, 0), mk(2050, 9, 23, 59, 59));
        send_pair(mk(2050, 9, 23, 59, 59), mk(2050, 10, 0, 0, 0));
        send_pair(mk(2001, 0, 0, 0, 0), mk(2000, 364, 23, 59, 59));
        send_pair(mk(2010, 0, 0, 0, 59), mk(2010, 0, 0, 0, 0));
        send_pair(mk(2010, 0, 0, 1, 0), mk(2010, 0, 0, 0, 0));
        send_pair(mk(2010, 0, 1, 0, 0), mk(2010, 0, 0, 0, 0));
        send_pair(mk(2010, 1, 0, 0, 0), mk(2010, 0, 0, 0, 0));
        send_pair(mk(2011, 0, 0, 0, 0), mk(2010, 0, 0, 0, 0));
        send_pair(mk(2010, 0, 0, 0, 0), mk(2011, 1, 1, 1, 1));
        // day 365 equals a whole year
        send_pair(mk(2040, 365, 0, 0, 0), mk(2041, 0, 0, 0, 0));
        // hundred years
        send_pair(mk(2100, 0, 0, 0, 0), mk(2000, 0, 0, 0, 0));
        // fields beyond their range, results wrap in their width
        send_pair(mk(2020, 511, 31, 63, 63), mk(2020, 0, 0, 0, 0));
        send_pair(mk(4095, 511, 31, 63, 63), mk(0, 0, 0, 0, 0));
        send_pair(mk(0, 0, 0, 0, 0), mk(4095, 511, 31, 63, 63));
        send_pair(mk(0, 511, 31, 63, 63), mk(4095, 0, 0, 0, 0));
    endtask

    task automatic test_calendar_random(input int count);
        stamp_t cur, tgt;
        for (int i = 0; i < count; i++)
        begin
            cur = rand_calendar_stamp();
            tgt = rand_calendar_stamp();
            // share leading fields often so small differences show up
            if ($urandom_range(0, 1))
                tgt.yr = cur.yr;
            if (tgt.yr == cur.yr && $urandom_range(0, 1))
                tgt.day = cur.day;
            if (tgt.day == cur.day && $urandom_range(0, 1))
                tgt.hr = cur.hr;
            if (tgt.hr == cur.hr && $urandom_range(0, 2) == 0)
                tgt.mn = cur.mn;
            send_pair(cur, tgt);
        end
    endtask

    task automatic test_drain_pause();
        for (int round = 0; round < 2; round++)
        begin
            test_calendar_random(30);
            wait_drained();
        end
    endtask

    task automatic test_full_width_random(input int count);
        for (int i = 0; i < count; i++)
            send_pair(rand_raw_stamp(), rand_raw_stamp());
    endtask

    // receiver stall patterns
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_THIRDS: m_axis_tready <= (rx_phase % 3) == 0;
            RX_CHOKE:  m_axis_tready <= (rx_phase % 16) < 4;
            default:   m_axis_tready <= 1'b1;
        endcase
    end

    // scoreboard
    always @(posedge clk)
    begin
        elapsed_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (elapsed_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none actual %0h",
                         $time, m_axis_tdata);
            end
            else
            begin
                e = elapsed_q.pop_front();
                check_field("total_seconds", 64'(e.tot_sec),
                            64'(m_axis_tdata[TSEC_LO +: TSEC_OUT_W]));
                check_field("total_minutes", 64'(e.tot_min),
                            64'(m_axis_tdata[TMIN_LO +: TMIN_OUT_W]));
                check_field("total_hours", 64'(e.tot_hr),
                            64'(m_axis_tdata[THR_LO +: THR_OUT_W]));
                check_field("part_seconds", 64'(e.sec),
                            64'(m_axis_tdata[PSEC_LO +: PSEC_OUT_W]));
                check_field("part_minutes", 64'(e.mins),
                            64'(m_axis_tdata[PMIN_LO +: PMIN_OUT_W]));
                check_field("part_hours", 64'(e.hrs),
                            64'(m_axis_tdata[PHR_LO +: PHR_OUT_W]));
                check_field("part_days", 64'(e.days),
                            64'(m_axis_tdata[PDAY_LO +: PDAY_OUT_W]));
                check_field("part_years", 64'(e.yrs),
                            64'(m_axis_tdata[PYR_LO +: PYR_OUT_W]));
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_calendar_random(600);
        test_drain_pause();
        test_full_width_random(520);
        test_calendar_random(500);

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (elapsed_q.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, elapsed_q.size());
        end

        $display("sent %0d timestamp pairs: extremes, borrow chains, calendar and raw-width random",
                 pairs_sent);
        $display("checked %0d result beats under random stalls, %0d field errors",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
